// ===== rtl/key_autorepeat_table_assert.svh =====
`ifndef KEY_AUTOREPEAT_TABLE_ASSERT_SVH
`define KEY_AUTOREPEAT_TABLE_ASSERT_SVH

// Checks a condition in the same cycle as its trigger.
`define KAT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks a condition in the cycle after its trigger.
`define KAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/kat_pkg.sv =====
`timescale 1ns / 1ps

package kat_pkg;

	localparam int NUM_KEYS = 256;
	localparam int KEY_W = $clog2(NUM_KEYS);
	localparam int STAMP_W = 32;
	localparam int TIME_W = 16;
	// One table entry: the time stamp above the repeated flag.
	localparam int ENTRY_W = STAMP_W + 1;
	localparam int ADDR_W = 3;

	localparam logic [TIME_W-1:0] DELAY_RESET = 16'd500;
	localparam logic [TIME_W-1:0] RATE_RESET = 16'd80;

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_POLL    = 2'd2
	} kat_op_t;

	typedef enum logic [0:0] {
		REG_DELAY = 1'b0,
		REG_RATE  = 1'b1
	} kat_reg_t;

	typedef enum logic [0:0] {
		ST_IDLE   = 1'b0,
		ST_ACCESS = 1'b1
	} kat_state_t;

endpackage

// ===== rtl/kat_ram.sv =====
`timescale 1ns / 1ps

module kat_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/key_autorepeat_table.sv =====
`timescale 1ns / 1ps
`include "key_autorepeat_table_assert.svh"

// Keyboard autorepeat engine. Each input word carries an operation (press,
// release or poll), a scan code and the current millisecond time. A press is
// echoed as a key-down word and stamps the key; a release is echoed as a
// key-up word. A poll of a held key yields a repeat key-down word once the
// time since its stamp exceeds the initial delay (first repeat) or the repeat
// rate (later repeats), and then restamps the key. Polls that find nothing
// due, unknown operations and scan codes beyond the table yield no word. The
// block takes a new word only once the last has left its access state: the
// stamp and repeated flag of each key sit in a synchronous RAM read as the
// word is taken, and the access state computes and writes the entry back. A
// finished result waits in an output register while the next word is taken;
// the block stalls only when a second result meets a full output register.
// No clearing pass is needed after reset: the held bits live in flip-flops
// and a key's RAM entry is only used after a press has written it. The delay
// (address 0x0) and rate (address 0x4) registers sit on the APB port and
// should be written only while the block is idle.

module key_autorepeat_table (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input stream.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [1:0] operation, [9:2] key_code, [41:10] now_ms, [47:42] zero
	input  logic [47:0]                  s_tdata,
	// Result stream.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [7:0] out_key, [8] pressed, [9] is_repeat, [15:10] zero
	output logic [15:0]                  m_tdata,
	// Register port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [kat_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	import kat_pkg::*;

	// Configuration registers.
	logic [TIME_W-1:0] delay_q;
	logic [TIME_W-1:0] rate_q;
	kat_reg_t          reg_sel;

	// Word under work.
	kat_state_t        state_q;
	kat_state_t        state_d;
	logic [1:0]        op_s1;
	logic [7:0]        key_s1;
	logic [STAMP_W-1:0] now_s1;
	logic [KEY_W-1:0]  idx_s1;
	logic              accept;

	// Key table.
	logic [NUM_KEYS-1:0] held_q;
	logic [ENTRY_W-1:0]  rd_entry;
	logic [ENTRY_W-1:0]  wr_entry;
	logic                mem_we;
	logic [STAMP_W-1:0]  stamp;
	logic                repeated;

	// Decision for the word in the access cycle.
	logic               key_ok;
	logic               held;
	logic               due;
	logic [STAMP_W-1:0] elapsed;
	logic [TIME_W-1:0]  limit;
	logic               emit;
	logic               res_pressed;
	logic               res_repeat;
	logic               advance;

	// Result register.
	logic              m_tvalid_q;
	logic [7:0]        out_key_q;
	logic              pressed_q;
	logic              is_repeat_q;

	//------------------------------------------------------------------
	// APB registers. The word address is taken from paddr[2].
	//------------------------------------------------------------------
	assign pready = 1'b1;
	assign reg_sel = kat_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			rate_q <= RATE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_DELAY: delay_q <= pwdata[TIME_W-1:0];
				REG_RATE:  rate_q <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DELAY: prdata = 32'(delay_q);
			REG_RATE:  prdata = 32'(rate_q);
			default:   prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Input capture. The RAM read is issued in the accept cycle.
	//------------------------------------------------------------------
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= s_tdata[1:0];
			key_s1 <= s_tdata[9:2];
			now_s1 <= s_tdata[41:10];
		end
	end

	assign idx_s1 = KEY_W'(key_s1);

	kat_ram #(
		.DEPTH(NUM_KEYS),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_s1),
		.wdata (wr_entry),
		.re    (accept),
		.raddr (KEY_W'(s_tdata[9:2])),
		.rdata (rd_entry)
	);

	assign stamp = rd_entry[ENTRY_W-1:1];
	assign repeated = rd_entry[0];

	//------------------------------------------------------------------
	// Repeat decision. A stamp later than now counts as maximal elapsed
	// time, which exceeds any 16-bit limit, so it is always due.
	//------------------------------------------------------------------
	always_comb begin
		key_ok = 32'(key_s1) < 32'(NUM_KEYS);
		held = held_q[idx_s1];
		elapsed = now_s1 - stamp;
		limit = repeated ? rate_q : delay_q;
		due = (stamp > now_s1) || (elapsed > 32'(limit));
		emit = 1'b0;
		res_pressed = 1'b0;
		res_repeat = 1'b0;
		wr_entry = {now_s1, 1'b0};
		case (kat_op_t'(op_s1))
			OP_PRESS: begin
				emit = key_ok;
				res_pressed = 1'b1;
			end
			OP_RELEASE: begin
				emit = key_ok;
			end
			OP_POLL: begin
				emit = key_ok && held && due;
				res_pressed = 1'b1;
				res_repeat = 1'b1;
				wr_entry = {now_s1, 1'b1};
			end
			default: ;
		endcase
	end

	//------------------------------------------------------------------
	// Control: idle, then the access state for each word, held while it stalls.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				if (advance) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// The access cycle stalls only while a new result meets a full output.
	always_comb begin
		s_tready = 1'b0;
		advance = 1'b0;
		mem_we = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_ACCESS: begin
				advance = !(emit && m_tvalid_q && !m_tready);
				mem_we = advance && emit
					&& ((kat_op_t'(op_s1) == OP_PRESS) || (kat_op_t'(op_s1) == OP_POLL));
			end
			default: ;
		endcase
	end

	// Held bits, cleared at reset so that no key reads as held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (advance && key_ok) begin
			if (kat_op_t'(op_s1) == OP_PRESS) begin
				held_q[idx_s1] <= 1'b1;
			end else if (kat_op_t'(op_s1) == OP_RELEASE) begin
				held_q[idx_s1] <= 1'b0;
			end
		end
	end

	//------------------------------------------------------------------
	// Output register.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_key_q <= key_s1;
			pressed_q <= res_pressed;
			is_repeat_q <= res_repeat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {6'b0, is_repeat_q, pressed_q, out_key_q};

	//------------------------------------------------------------------
	// Assertions.
	//------------------------------------------------------------------
	`KAT_ASSERT_NEXT(a_accept_to_access, accept, state_q == ST_ACCESS,
		"accepted word did not enter the access cycle")
	`KAT_ASSERT_NEXT(a_stall_holds, (state_q == ST_ACCESS) && !advance,
		(state_q == ST_ACCESS) && m_tvalid_q, "stalled word left the access cycle")
	`KAT_ASSERT_NEXT(a_press_holds_key,
		advance && key_ok && (kat_op_t'(op_s1) == OP_PRESS), held_q[idx_s1],
		"pressed key not marked held")
	`KAT_ASSERT_SAME(a_write_in_access, mem_we, (state_q == ST_ACCESS) && emit,
		"table written outside a result-producing access")

endmodule
